FILE: rtl/core/mma_pkg.sv
// Shared types and constants of the matrix multiply-accumulate block.
`timescale 1ns / 1ps
package mma_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_LOAD_C  = 2'd2,
        MODE_COMPUTE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_ALPHA = 3'd0,
        CFG_BETA  = 3'd1,
        CFG_ROWS  = 3'd2,
        CFG_COLS  = 3'd3,
        CFG_INNER = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] element_value;
    } t_item;

    typedef struct packed {
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic signed [31:0] result_value;
        logic               last;
    } t_result;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

endpackage

FILE: rtl/core/mma_front.sv
// Front end: accepts transactions, drops the ones without effect, queues the rest.
`timescale 1ns / 1ps
module mma_front #(
    parameter int MAX_DIM = 16,
    parameter int DW      = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  mma_pkg::t_item i_item,
    input  logic [DW-1:0]  i_dim_m,
    input  logic [DW-1:0]  i_dim_n,
    output logic           o_cmd_valid,
    output mma_pkg::t_item o_cmd,
    input  logic           i_pop
);

    mma_pkg::t_item r_q [mma_pkg::QDEPTH];
    logic [mma_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [mma_pkg::QPTR_W:0]   r_cnt, n_cnt;
    logic keep, push;

    // Out-of-store loads, out-of-matrix rows and computes with no columns never queue.
    always_comb begin
        if (i_item.mode == mma_pkg::MODE_COMPUTE) begin
            keep = (int'(i_item.row_index) < int'(i_dim_m)) && (i_dim_n != '0);
        end else begin
            keep = (int'(i_item.row_index) < MAX_DIM) && (int'(i_item.col_index) < MAX_DIM);
        end
    end

    assign o_busy      = (int'(r_cnt) == mma_pkg::QDEPTH);
    assign push        = i_start && !o_busy && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= mma_pkg::QDEPTH)
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_cnt != '0))
        else $error("queued transaction lost");

endmodule

FILE: rtl/core/mma_back.sv
// Back end: the three stores and the single-MAC row sequencer.
`timescale 1ns / 1ps
module mma_back #(
    parameter int MAX_DIM = 16,
    parameter int DW      = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  mma_pkg::t_item      i_cmd,
    output logic                o_pop,
    input  logic [DW-1:0]       i_dim_n,
    input  logic [DW-1:0]       i_dim_k,
    input  logic signed [15:0]  i_alpha,
    input  logic signed [15:0]  i_beta,
    output logic                o_valid,
    output mma_pkg::t_result    o_result
);

    localparam int IW     = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = 32 + $clog2(MAX_DIM);
    localparam int PW     = AW + 16;
    localparam int TW     = PW + 1;

    logic signed [15:0] r_mem_a [DEPTH];
    logic signed [15:0] r_mem_b [DEPTH];
    logic signed [15:0] r_mem_c [DEPTH];

    mma_pkg::t_state r_state, n_state;
    logic [3:0]          r_row;
    logic [IW-1:0]       r_j, r_k;
    logic                r_v1, r_v2;
    logic signed [15:0]  r_a_q, r_b_q, r_c_q;
    logic signed [31:0]  r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [PW-1:0] r_aprod;
    logic signed [31:0]  r_bprod;
    logic                r_valid;
    mma_pkg::t_result    r_res;

    logic is_compute, issue, col_start, last_col, k_done, no_k;
    logic [ADDR_W-1:0] waddr, addr_a, addr_b, addr_c;
    logic signed [TW-1:0] total, shifted;
    logic signed [31:0] sat;

    assign is_compute = (i_cmd.mode == mma_pkg::MODE_COMPUTE);
    assign last_col   = (DW'(r_j) == i_dim_n - 1'b1);
    assign k_done     = (DW'(r_k) == i_dim_k - 1'b1);
    assign no_k       = (i_dim_k == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mma_pkg::ST_IDLE: begin
                if (i_cmd_valid && is_compute) begin
                    n_state = no_k ? mma_pkg::ST_DRAIN : mma_pkg::ST_MAC;
                end
            end
            mma_pkg::ST_MAC: begin
                if (k_done) begin
                    n_state = mma_pkg::ST_DRAIN;
                end
            end
            mma_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = mma_pkg::ST_SCALE;
                end
            end
            mma_pkg::ST_SCALE: n_state = mma_pkg::ST_OUT;
            mma_pkg::ST_OUT: begin
                if (last_col) begin
                    n_state = mma_pkg::ST_IDLE;
                end else begin
                    n_state = no_k ? mma_pkg::ST_DRAIN : mma_pkg::ST_MAC;
                end
            end
            default: n_state = mma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        issue     = 1'b0;
        col_start = 1'b0;
        case (r_state)
            mma_pkg::ST_IDLE: begin
                o_pop     = i_cmd_valid;
                col_start = i_cmd_valid && is_compute;
            end
            mma_pkg::ST_MAC: issue = 1'b1;
            mma_pkg::ST_OUT: col_start = !last_col;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign waddr  = ADDR_W'(i_cmd.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(i_cmd.col_index);
    assign addr_a = ADDR_W'(r_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);
    assign addr_b = ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);
    assign addr_c = ADDR_W'(r_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.mode == mma_pkg::MODE_LOAD_A) begin
            r_mem_a[waddr] <= i_cmd.element_value;
        end
        if (issue) begin
            r_a_q <= r_mem_a[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.mode == mma_pkg::MODE_LOAD_B) begin
            r_mem_b[waddr] <= i_cmd.element_value;
        end
        if (issue) begin
            r_b_q <= r_mem_b[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.mode == mma_pkg::MODE_LOAD_C) begin
            r_mem_c[waddr] <= i_cmd.element_value;
        end
        r_c_q <= r_mem_c[addr_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mma_pkg::ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_valid <= (r_state == mma_pkg::ST_OUT);
        end
    end

    // Total is in Q45.8 (at MAX_DIM = 16); adding half an LSB and shifting right gives round-half-up.
    always_comb begin
        total   = TW'(r_aprod) + (TW'(r_bprod) <<< 8) + TW'(128);
        shifted = total >>> 8;
        if ((&shifted[TW-1:31]) || !(|shifted[TW-1:31])) begin
            sat = shifted[31:0];
        end else if (shifted[TW-1]) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        if (o_pop && is_compute) begin
            r_row <= i_cmd.row_index;
            r_j   <= '0;
        end else if (r_state == mma_pkg::ST_OUT) begin
            r_j <= r_j + 1'b1;
        end
        if (col_start) begin
            r_k   <= '0;
            r_acc <= '0;
        end else begin
            if (issue) begin
                r_k <= r_k + 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_acc + AW'(r_prod);
            end
        end
        if (r_state == mma_pkg::ST_SCALE) begin
            r_aprod <= i_alpha * r_acc;
            r_bprod <= i_beta * r_c_q;
        end
        if (r_state == mma_pkg::ST_OUT) begin
            r_res.out_row      <= r_row;
            r_res.out_col      <= 4'(r_j);
            r_res.result_value <= sat;
            r_res.last         <= last_col;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == mma_pkg::ST_OUT))
        else $error("result strobe without a finished column");
    a_scale_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_SCALE) |-> (!r_v1 && !r_v2))
        else $error("scaling before the product pipeline drained");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == mma_pkg::ST_IDLE))
        else $error("queue popped while a row is in progress");

endmodule

FILE: rtl/core/matrix_multiply_accumulate.sv
// Top level of the matrix multiply-accumulate block: configuration registers and the two halves.
//
// Channel   Direction  Handshake                      Payload
// input     in         i_start & !o_busy              i_item (mma_pkg::t_item)
// result    out        o_valid, one cycle, no stall   o_result (mma_pkg::t_result)
// config    in         i_cfg_we                       i_cfg_idx, i_cfg_wdata
//
// The back end writes a load transaction to its store as it pops it. A compute transaction
// runs its row column by column: the single multiply-accumulate unit steps through inner_k
// products for each column, then the sum is scaled and rounded. With inner_k at zero a column
// skips the products.
// A four-entry queue parts the front end from the back end; o_busy is high while it is full.
// Reset is synchronous and active low; the stores are not cleared and the queue empties.
// The receiver cannot stall: each result is flagged by o_valid for exactly one cycle.
`timescale 1ns / 1ps
module matrix_multiply_accumulate #(
    parameter int MAX_DIM = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  mma_pkg::t_item   i_item,
    output logic             o_valid,
    output mma_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_wdata
);

    localparam int DW = $clog2(MAX_DIM + 1);

    logic signed [15:0] r_alpha, r_beta;
    logic [4:0]         r_rows, r_cols, r_inner;
    logic [DW-1:0]      dim_m, dim_n, dim_k;
    logic               cmd_valid, pop;
    mma_pkg::t_item     cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 16'sd256;
            r_beta  <= 16'sd0;
            r_rows  <= 5'd16;
            r_cols  <= 5'd16;
            r_inner <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mma_pkg::CFG_ALPHA: r_alpha <= i_cfg_wdata;
                mma_pkg::CFG_BETA:  r_beta  <= i_cfg_wdata;
                mma_pkg::CFG_ROWS:  r_rows  <= i_cfg_wdata[4:0];
                mma_pkg::CFG_COLS:  r_cols  <= i_cfg_wdata[4:0];
                mma_pkg::CFG_INNER: r_inner <= i_cfg_wdata[4:0];
                default: begin
                    r_rows <= r_rows;
                end
            endcase
        end
    end

    // Dimensions above the store size act as the store size.
    assign dim_m = (int'(r_rows) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_rows);
    assign dim_n = (int'(r_cols) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_cols);
    assign dim_k = (int'(r_inner) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_inner);

    mma_front #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_dim_m     (dim_m),
        .i_dim_n     (dim_n),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    mma_back #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_dim_n     (dim_n),
        .i_dim_k     (dim_k),
        .i_alpha     (r_alpha),
        .i_beta      (r_beta),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule
